@@ rtl/core/tls_pkg.sv @@
// tally link supervisor package: codes, item types and lamp pattern helpers
`default_nettype none
package tls_pkg;

  localparam int unsigned TICKS_PER_PATTERN_BIT = 10;

  localparam int unsigned SRC_W    = 16;
  localparam int unsigned PHASE_W  = 9;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  // phase / TICKS_PER_PATTERN_BIT as a multiply by a rounded-up reciprocal
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP =
    ((2 ** RECIP_SHIFT) + TICKS_PER_PATTERN_BIT - 1) / TICKS_PER_PATTERN_BIT;
  localparam int unsigned PROD_W = PHASE_W + RECIP_SHIFT + 1;
  localparam int unsigned IDX_W = PROD_W - RECIP_SHIFT;

  typedef enum logic [2:0] {
    ST_RADIO      = 3'd0,
    ST_HOST       = 3'd1,
    ST_PEER       = 3'd2,
    ST_RUN_MASTER = 3'd3,
    ST_RUN_PEER   = 3'd4,
    ST_ERROR      = 3'd5
  } link_state_t;

  // force codes from this value upwards leave the state alone
  localparam logic [2:0] FORCE_NONE = 3'd6;

  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_START_RADIO   = 3'd1,
    ACT_CONNECT_HOST  = 3'd2,
    ACT_START_MASTER  = 3'd3,
    ACT_START_PEER    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STEP_START = 2'd0,
    STEP_WAIT  = 2'd1,
    STEP_DONE  = 2'd2,
    STEP_IDLE  = 2'd3
  } step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_ID = 2'd0,
    REG_IS_MASTER = 2'd1,
    REG_TIMEOUT   = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SRC_W-1:0] camera_id;
    logic             is_master;
    logic [15:0]      timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         force_state;
    logic [PHASE_W-1:0] tick_phase;
    logic               wifi_up;
    logic               host_up;
    logic               peer_message;
    logic [SRC_W-1:0]   preview_source;
    logic [SRC_W-1:0]   program_source;
    logic               transition_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] link_state;
    logic [2:0] action;
    logic       forward_update;
    logic       tally_valid;
    logic       preview_lamp;
    logic       program_lamp;
    logic       transition_flag;
    logic       status_led;
  } res_t;

  localparam logic [31:0] PAT_RADIO   = 32'h0000_0001;
  localparam logic [31:0] PAT_HOST    = 32'h0000_0005;
  localparam logic [31:0] PAT_PEER    = 32'h0000_0015;
  localparam logic [31:0] PAT_ERROR   = 32'h0000_00FF;
  localparam logic [31:0] PAT_FROZEN  = 32'h00FF_00FF;
  localparam logic [31:0] PAT_PREVIEW = 32'h5555_5555;
  localparam logic [31:0] PAT_PROGRAM = 32'hFFFF_FFFF;

  // blink pattern for the states that are not running
  function automatic logic [31:0] state_pattern(input logic [2:0] st);
    logic [31:0] p;
    begin
      unique case (st)
        ST_RADIO: p = PAT_RADIO;
        ST_HOST:  p = PAT_HOST;
        ST_PEER:  p = PAT_PEER;
        ST_RUN_MASTER, ST_RUN_PEER: p = 32'h0;
        default:  p = PAT_ERROR;
      endcase
      return p;
    end
  endfunction

  // pattern bit index for a blink phase
  function automatic logic [IDX_W-1:0] phase_index(input logic [PHASE_W-1:0] ph);
    logic [PROD_W-1:0] prod;
    begin
      prod = PROD_W'(ph) * PROD_W'(RECIP);
      return prod[PROD_W-1:RECIP_SHIFT];
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/tls_in_if.sv @@
// tick item channel
`default_nettype none
interface tls_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  force_state;
  logic [8:0]  tick_phase;
  logic        wifi_up;
  logic        host_up;
  logic        peer_message;
  logic [15:0] preview_source;
  logic [15:0] program_source;
  logic        transition_in;

  modport source (
    output valid, force_state, tick_phase, wifi_up, host_up, peer_message,
           preview_source, program_source, transition_in,
    input  ready
  );
  modport sink (
    input  valid, force_state, tick_phase, wifi_up, host_up, peer_message,
           preview_source, program_source, transition_in,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/core/tls_out_if.sv @@
// result item channel
`default_nettype none
interface tls_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] link_state;
  logic [2:0] action;
  logic       forward_update;
  logic       tally_valid;
  logic       preview_lamp;
  logic       program_lamp;
  logic       transition_flag;
  logic       status_led;

  modport source (
    output valid, link_state, action, forward_update, tally_valid, preview_lamp,
           program_lamp, transition_flag, status_led,
    input  ready
  );
  modport sink (
    input  valid, link_state, action, forward_update, tally_valid, preview_lamp,
           program_lamp, transition_flag, status_led,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/core/tls_cfg_if.sv @@
// register write channel
`default_nettype none
interface tls_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tls_cfg.sv @@
// configuration register bank
`default_nettype none
module tls_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_index,
  input  wire logic [15:0]   wr_data,
  output tls_pkg::cfg_t      cfg
);
  import tls_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.camera_id     <= '0;
      cfg_r.is_master     <= 1'b0;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_CAMERA_ID: cfg_r.camera_id     <= wr_data;
        REG_IS_MASTER: cfg_r.is_master     <= wr_data[0];
        REG_TIMEOUT:   cfg_r.timeout_ticks <= wr_data;
        REG_UNUSED:    ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/core/tls_step.sv @@
// link state, silence timer and tally latch; forms the result for one tick
`default_nettype none
module tls_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire tls_pkg::cfg_t     cfg,
  input  wire tls_pkg::in_item_t item,
  output tls_pkg::res_t          res
);
  import tls_pkg::*;

  logic [2:0]        state_r, state_nxt, state_f;
  step_t             radio_r, radio_nxt, radio_f;
  step_t             host_r, host_nxt, host_f;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [TICK_W-1:0] heard_r, heard_nxt, heard_eff;
  logic              frozen_r, frozen_nxt;
  logic [2:0]        tally_r, tally_nxt, tally_new;
  logic              heard;
  logic              silent;
  logic              running;
  action_t           action;
  logic              forward;
  logic [31:0]       pattern;
  logic [IDX_W-1:0]  idx;

  assign tick_nxt = tick_r + 1'b1;
  assign tally_new = {item.transition_in,
                      item.program_source == cfg.camera_id,
                      item.preview_source == cfg.camera_id};

  always_comb begin
    if (item.force_state < FORCE_NONE) begin
      state_f = item.force_state;
    end else begin
      state_f = state_r;
    end
    radio_f = (item.force_state == ST_RADIO) ? STEP_START : radio_r;
    host_f  = (item.force_state == ST_HOST)  ? STEP_START : host_r;

    // news that refreshes the last-heard stamp this tick
    heard = ((state_f == ST_RUN_MASTER) && item.host_up) ||
            ((state_f == ST_RUN_PEER) && item.peer_message);
    heard_eff = heard ? tick_nxt : heard_r;
    silent = (tick_nxt - heard_eff) > TICK_W'(cfg.timeout_ticks);

    state_nxt  = state_f;
    radio_nxt  = radio_f;
    host_nxt   = host_f;
    heard_nxt  = heard_r;
    frozen_nxt = frozen_r;
    tally_nxt  = tally_r;
    action     = ACT_NONE;
    forward    = 1'b0;

    unique case (state_f)
      ST_RADIO: begin
        unique case (radio_f)
          STEP_START: begin
            action    = ACT_START_RADIO;
            radio_nxt = STEP_WAIT;
          end
          STEP_WAIT: begin
            if (item.wifi_up) begin
              radio_nxt = STEP_DONE;
            end
          end
          STEP_DONE: begin
            radio_nxt = STEP_START;
            if (cfg.is_master) begin
              state_nxt = ST_HOST;
              action    = ACT_START_MASTER;
            end else begin
              state_nxt = ST_PEER;
              action    = ACT_START_PEER;
            end
          end
          STEP_IDLE: radio_nxt = STEP_START;
        endcase
      end
      ST_HOST: begin
        unique case (host_f)
          STEP_START: begin
            action   = ACT_CONNECT_HOST;
            host_nxt = STEP_WAIT;
          end
          STEP_WAIT: begin
            if (item.host_up) begin
              host_nxt = STEP_DONE;
            end
          end
          STEP_DONE: begin
            host_nxt  = STEP_START;
            state_nxt = ST_RUN_MASTER;
          end
          STEP_IDLE: host_nxt = STEP_START;
        endcase
      end
      ST_PEER: state_nxt = ST_RUN_PEER;
      ST_RUN_MASTER: begin
        heard_nxt = heard_eff;
        if (item.host_up) begin
          frozen_nxt = 1'b0;
        end
        if (silent) begin
          // lost the host: back to connecting
          frozen_nxt = 1'b1;
          state_nxt  = ST_HOST;
          host_nxt   = STEP_START;
        end else if (!(frozen_r && !item.host_up)) begin
          tally_nxt = tally_new;
          forward   = 1'b1;
        end
      end
      ST_RUN_PEER: begin
        heard_nxt = heard_eff;
        if (item.peer_message) begin
          tally_nxt  = tally_new;
          frozen_nxt = 1'b0;
        end
        if (silent) begin
          frozen_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    running = (state_nxt == ST_RUN_MASTER) || (state_nxt == ST_RUN_PEER);

    if (!running) begin
      pattern = state_pattern(state_nxt);
    end else if (frozen_nxt) begin
      pattern = PAT_FROZEN;
    end else if (tally_nxt[1]) begin
      pattern = PAT_PROGRAM;
    end else if (tally_nxt[0]) begin
      pattern = PAT_PREVIEW;
    end else begin
      pattern = 32'h0;
    end
  end

  assign idx = phase_index(item.tick_phase);

  always_comb begin
    res.link_state      = state_nxt;
    res.action          = action;
    res.forward_update  = forward;
    res.tally_valid     = running && !frozen_nxt;
    res.preview_lamp    = tally_nxt[0];
    res.program_lamp    = tally_nxt[1];
    res.transition_flag = tally_nxt[2];
    res.status_led      = (idx < IDX_W'(32)) ? pattern[idx[4:0]] : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RADIO;
      radio_r  <= STEP_START;
      host_r   <= STEP_START;
      tick_r   <= '0;
      heard_r  <= '0;
      frozen_r <= 1'b0;
      tally_r  <= '0;
    end else if (advance) begin
      state_r  <= state_nxt;
      radio_r  <= radio_nxt;
      host_r   <= host_nxt;
      tick_r   <= tick_nxt;
      heard_r  <= heard_nxt;
      frozen_r <= frozen_nxt;
      tally_r  <= tally_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tally_link_supervisor_unit.sv @@
// Tally link supervisor: link sequencing, silence watch, tally lamps and status LED.
//
// One input item is one 10 ms tick. in_ch carries the forced state, blink
// phase, link flags and the preview/program sources; out_ch returns one result
// item per tick: link state, action code, forward flag, tally valid, the three
// latched tally bits and the status LED bit. cfg_ch writes camera_id (index 0),
// is_master (index 1) and timeout_ticks (index 2); it is always ready and must
// only be used while no tick is in flight.
// An accepted item sits in the input register while the step
// logic updates the link state and forms the result, which lands in the output
// register and drives out_ch.valid. One item per cycle is sustained while out_ch
// is not stalled; the path from input register to result register is the
// single update of the state registers.
// While out_ch is stalled the result holds and one further item waits in the
// input register; in_ch.ready drops only when both are full.
// Synchronous reset puts the link in radio connect with cleared counters,
// timers and tally bits, and the registers at camera 0, slave, 200 ticks.
`default_nettype none
module tally_link_supervisor_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  tls_in_if.sink    in_ch,
  tls_out_if.source out_ch,
  tls_cfg_if.sink   cfg_ch
);
  import tls_pkg::*;

  cfg_t     cfg;
  in_item_t item_r;
  logic     item_vld_r;
  res_t     res;
  res_t     res_r;
  logic     res_vld_r;
  logic     advance;
  logic     in_take;

  assign cfg_ch.ready = 1'b1;

  tls_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // input register moves on when the result register is free or being taken
  assign advance     = item_vld_r && (!res_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  tls_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg),
    .item    (item_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_take) begin
        item_vld_r <= 1'b1;
      end else if (advance) begin
        item_vld_r <= 1'b0;
      end
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.force_state    <= in_ch.force_state;
      item_r.tick_phase     <= in_ch.tick_phase;
      item_r.wifi_up        <= in_ch.wifi_up;
      item_r.host_up        <= in_ch.host_up;
      item_r.peer_message   <= in_ch.peer_message;
      item_r.preview_source <= in_ch.preview_source;
      item_r.program_source <= in_ch.program_source;
      item_r.transition_in  <= in_ch.transition_in;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid           = res_vld_r;
  assign out_ch.link_state      = res_r.link_state;
  assign out_ch.action          = res_r.action;
  assign out_ch.forward_update  = res_r.forward_update;
  assign out_ch.tally_valid     = res_r.tally_valid;
  assign out_ch.preview_lamp    = res_r.preview_lamp;
  assign out_ch.program_lamp    = res_r.program_lamp;
  assign out_ch.transition_flag = res_r.transition_flag;
  assign out_ch.status_led      = res_r.status_led;

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench for the tally link supervisor: tick driver, result monitor and predictor
module tb_top;
  import tls_pkg::*;

  // the spare force code behaves like no forced change
  localparam logic [2:0] FORCE_SPARE = 3'd7;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned HOLD_OFF_AT = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;

  tls_in_if  in_bus ();
  tls_out_if out_bus ();
  tls_cfg_if cfg_bus ();

  tally_link_supervisor_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ticks waiting to be offered and results the block still owes
  in_item_t tick_q[$];
  res_t     result_q[$];
  bit       no_gaps = 1'b0;
  int       mismatches = 0;

  // predictor copy of registers and link state
  logic [15:0]  cam_id;
  logic         master_mode;
  logic [15:0]  silence_limit;
  link_state_t  link_st;
  step_t        radio_ph;
  step_t        host_ph;
  logic [31:0]  tick_cnt;
  logic [31:0]  heard_at;
  logic         stale;
  logic [2:0]   lamps;

  function automatic logic [2:0] latch_lamps(in_item_t t);
    return {t.transition_in, t.program_source == cam_id, t.preview_source == cam_id};
  endfunction

  function automatic res_t advance_link(in_item_t t);
    res_t        r;
    action_t     act;
    logic        fwd;
    logic        running;
    logic [31:0] gap;
    logic [31:0] pat;
    int unsigned bit_idx;
    begin
      act = ACT_NONE;
      fwd = 1'b0;
      tick_cnt = tick_cnt + 32'd1;
      if (t.force_state < FORCE_NONE) begin
        link_st = link_state_t'(t.force_state);
        if (t.force_state == ST_RADIO) radio_ph = STEP_START;
        if (t.force_state == ST_HOST) host_ph = STEP_START;
      end
      case (link_st)
        ST_RADIO: begin
          case (radio_ph)
            STEP_START: begin
              act = ACT_START_RADIO;
              radio_ph = STEP_WAIT;
            end
            STEP_WAIT: if (t.wifi_up) radio_ph = STEP_DONE;
            STEP_DONE: begin
              radio_ph = STEP_START;
              if (master_mode) begin
                link_st = ST_HOST;
                act = ACT_START_MASTER;
              end else begin
                link_st = ST_PEER;
                act = ACT_START_PEER;
              end
            end
            default: radio_ph = STEP_START;
          endcase
        end
        ST_HOST: begin
          case (host_ph)
            STEP_START: begin
              act = ACT_CONNECT_HOST;
              host_ph = STEP_WAIT;
            end
            STEP_WAIT: if (t.host_up) host_ph = STEP_DONE;
            STEP_DONE: begin
              host_ph = STEP_START;
              link_st = ST_RUN_MASTER;
            end
            default: host_ph = STEP_START;
          endcase
        end
        ST_PEER: link_st = ST_RUN_PEER;
        ST_RUN_MASTER: begin
          if (t.host_up) begin
            stale = 1'b0;
            heard_at = tick_cnt;
          end
          gap = tick_cnt - heard_at;
          if (gap > {16'h0, silence_limit}) begin
            stale = 1'b1;
            link_st = ST_HOST;
            host_ph = STEP_START;
          end
          if (!stale) begin
            lamps = latch_lamps(t);
            fwd = 1'b1;
          end
        end
        ST_RUN_PEER: begin
          if (t.peer_message) begin
            lamps = latch_lamps(t);
            heard_at = tick_cnt;
            stale = 1'b0;
          end
          gap = tick_cnt - heard_at;
          if (gap > {16'h0, silence_limit}) stale = 1'b1;
        end
        default: ;
      endcase

      running = (link_st == ST_RUN_MASTER) || (link_st == ST_RUN_PEER);
      if (running) begin
        if (stale) pat = PAT_FROZEN;
        else pat = (lamps[0] ? PAT_PREVIEW : 32'h0) | (lamps[1] ? PAT_PROGRAM : 32'h0);
      end else begin
        case (link_st)
          ST_RADIO: pat = PAT_RADIO;
          ST_HOST:  pat = PAT_HOST;
          ST_PEER:  pat = PAT_PEER;
          default:  pat = PAT_ERROR;
        endcase
      end
      bit_idx = t.tick_phase / TICKS_PER_PATTERN_BIT;

      r.link_state      = link_st;
      r.action          = act;
      r.forward_update  = fwd;
      r.tally_valid     = running && !stale;
      r.preview_lamp    = lamps[0];
      r.program_lamp    = lamps[1];
      r.transition_flag = lamps[2];
      r.status_led      = (bit_idx < 32) ? pat[bit_idx] : 1'b0;
      return r;
    end
  endfunction

  function automatic in_item_t mk(logic [2:0] f, int unsigned ph, bit wifi, bit host,
                                  bit peer, logic [15:0] pv, logic [15:0] pg, bit tr);
    in_item_t t;
    begin
      t.force_state    = f;
      t.tick_phase     = ph[PHASE_W-1:0];
      t.wifi_up        = wifi;
      t.host_up        = host;
      t.peer_message   = peer;
      t.preview_source = pv;
      t.program_source = pg;
      t.transition_in  = tr;
      return t;
    end
  endfunction

  // often this camera's number so the lamps light, with the extremes now and then
  function automatic logic [15:0] pick_src();
    int unsigned r;
    begin
      r = $urandom_range(99);
      if (r < 40) return cam_id;
      if (r < 50) return 16'h0000;
      if (r < 60) return 16'hFFFF;
      return 16'($urandom);
    end
  endfunction

  function automatic in_item_t make_tick(int unsigned link_pct);
    logic [2:0]  f;
    int unsigned ph;
    begin
      if ($urandom_range(99) < 6) f = 3'($urandom_range(7));
      else f = $urandom_range(1) ? FORCE_NONE : FORCE_SPARE;
      if ($urandom_range(9) == 0) ph = $urandom_range(511, 320);
      else ph = $urandom_range(319);
      return mk(f, ph, $urandom_range(99) < link_pct, $urandom_range(99) < link_pct,
                $urandom_range(99) < link_pct, pick_src(), pick_src(), $urandom_range(1));
    end
  endfunction

  // tick driver
  always @(posedge clk) begin : tick_driver
    bit taken;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      taken = in_bus.valid && in_bus.ready;
      if (taken) result_q.push_back(advance_link(tick_q.pop_front()));
      if (!in_bus.valid || taken) begin
        if (tick_q.size() != 0 && (no_gaps || $urandom_range(99) >= 31)) begin
          in_bus.valid          <= 1'b1;
          in_bus.force_state    <= tick_q[0].force_state;
          in_bus.tick_phase     <= tick_q[0].tick_phase;
          in_bus.wifi_up        <= tick_q[0].wifi_up;
          in_bus.host_up        <= tick_q[0].host_up;
          in_bus.peer_message   <= tick_q[0].peer_message;
          in_bus.preview_source <= tick_q[0].preview_source;
          in_bus.program_source <= tick_q[0].program_source;
          in_bus.transition_in  <= tick_q[0].transition_in;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result monitor, with one long hold-off to back the block up
  always @(posedge clk) begin : result_monitor
    res_t        want;
    int unsigned seen;
    int unsigned hold_left;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      seen = 0;
      hold_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (result_q.size() == 0) begin
          $error("result item with nothing expected");
          mismatches++;
        end else begin
          want = result_q.pop_front();
          check_field("link_state", want.link_state, out_bus.link_state);
          check_field("action", want.action, out_bus.action);
          check_field("forward_update", want.forward_update, out_bus.forward_update);
          check_field("tally_valid", want.tally_valid, out_bus.tally_valid);
          check_field("preview_lamp", want.preview_lamp, out_bus.preview_lamp);
          check_field("program_lamp", want.program_lamp, out_bus.program_lamp);
          check_field("transition_flag", want.transition_flag, out_bus.transition_flag);
          check_field("status_led", want.status_led, out_bus.status_led);
        end
        seen++;
        if (seen == HOLD_OFF_AT) hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= no_gaps || ($urandom_range(99) >= 31);
      end
    end
  end

  // cycles with no item moving on any channel
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n) begin
      quiet = 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                 (cfg_bus.valid && cfg_bus.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic drain();
    do @(negedge clk); while (tick_q.size() != 0 || result_q.size() != 0);
  endtask

  // called on a rising edge; leaves the channel valid for a following write
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_CAMERA_ID: cam_id = val;
      REG_IS_MASTER: master_mode = val[0];
      REG_TIMEOUT:   silence_limit = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [15:0] cam, bit master, logic [15:0] tmo,
                           int unsigned count, int unsigned link_pct, bit calm);
    drain();
    @(posedge clk);
    write_reg(REG_CAMERA_ID, cam);
    write_reg(REG_IS_MASTER, {15'h0, master});
    write_reg(REG_TIMEOUT, tmo);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
    no_gaps = calm;
    repeat (count) tick_q.push_back(make_tick(link_pct));
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.force_state = FORCE_NONE;
    in_bus.tick_phase = '0;
    in_bus.wifi_up = 1'b0;
    in_bus.host_up = 1'b0;
    in_bus.peer_message = 1'b0;
    in_bus.preview_source = '0;
    in_bus.program_source = '0;
    in_bus.transition_in = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_CAMERA_ID;
    cfg_bus.data = '0;

    cam_id = '0;
    master_mode = 1'b0;
    silence_limit = TIMEOUT_RESET;
    link_st = ST_RADIO;
    radio_ph = STEP_START;
    host_ph = STEP_START;
    tick_cnt = '0;
    heard_at = '0;
    stale = 1'b0;
    lamps = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed walk under the reset registers: slave, camera 0
    tick_q.push_back(mk(FORCE_NONE, 0, 0, 0, 0, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(FORCE_NONE, 9, 0, 1, 1, 16'hFFFF, 16'hFFFF, 1));
    tick_q.push_back(mk(FORCE_NONE, 10, 1, 0, 0, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(FORCE_NONE, 20, 0, 0, 0, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(FORCE_NONE, 30, 0, 0, 0, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(FORCE_NONE, 319, 0, 0, 1, 16'h0000, 16'hFFFF, 1));
    // blink index past the pattern
    tick_q.push_back(mk(FORCE_NONE, 320, 0, 0, 1, 16'hFFFF, 16'h0000, 0));
    tick_q.push_back(mk(FORCE_SPARE, 511, 1, 1, 0, 16'h0000, 16'h0000, 1));
    tick_q.push_back(mk(ST_ERROR, 15, 1, 1, 1, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(FORCE_NONE, 75, 1, 1, 1, 16'h0000, 16'h0000, 1));
    tick_q.push_back(mk(ST_HOST, 40, 1, 0, 0, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(FORCE_NONE, 41, 1, 1, 0, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(FORCE_NONE, 42, 1, 1, 0, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(FORCE_NONE, 50, 1, 1, 0, 16'h0000, 16'h0000, 1));
    tick_q.push_back(mk(FORCE_NONE, 60, 1, 0, 0, 16'hFFFF, 16'h0000, 0));
    tick_q.push_back(mk(ST_RUN_PEER, 70, 0, 0, 0, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(ST_PEER, 80, 0, 0, 1, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(FORCE_NONE, 90, 0, 0, 1, 16'h0000, 16'h0000, 1));
    tick_q.push_back(mk(ST_RUN_MASTER, 100, 0, 1, 0, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(ST_RADIO, 200, 1, 0, 0, 16'h0000, 16'h0000, 0));
    tick_q.push_back(mk(ST_RADIO, 310, 1, 0, 0, 16'h0000, 16'h0000, 0));
    repeat (60) tick_q.push_back(make_tick(80));

    // zero timeout: every silent tick freezes
    run_phase(16'hFFFF, 1'b1, 16'h0000, 110, 70, 1'b0);
    run_phase(16'd5, 1'b0, 16'd3, 110, 60, 1'b0);
    // a stretch with no idling on either side
    run_phase(16'd7, 1'b1, 16'hFFFF, 110, 90, 1'b1);
    run_phase(16'h0000, 1'b0, 16'd10, 110, 75, 1'b0);
    run_phase(16'd300, 1'b1, 16'd12, 100, 65, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ tally_link_supervisor_unit.f @@
rtl/core/tls_pkg.sv
rtl/core/tls_in_if.sv
rtl/core/tls_out_if.sv
rtl/core/tls_cfg_if.sv
rtl/core/tls_cfg.sv
rtl/core/tls_step.sv
rtl/core/tally_link_supervisor_unit.sv
sim/tb_top.sv
